FILE: rtl/core/sad_pkg.sv
// ----------------------------------------------------------------------------
// Spectral anomaly detector package
// Shared widths, constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package sad_pkg;

  localparam int unsigned LogDepthDef = 16;
  localparam int unsigned MaxBinsDef  = 1024;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AngleW = 16;
  localparam int unsigned BinW   = 10;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CntW   = 5;
  localparam int unsigned CoolW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned AddrW  = 4;

  localparam logic [DataW-1:0] ThreshReset   = 32'h0003_0000;
  localparam logic [DataW-1:0] ThreshOne     = 32'h0001_0000;
  localparam logic [CoolW-1:0] CooldownReset = 8'd10;

  localparam logic [KindW-1:0] KindBin   = 2'd0;
  localparam logic [KindW-1:0] KindRead  = 2'd1;
  localparam logic [KindW-1:0] KindClear = 2'd2;
  // Unused code; such a transaction is dropped without a result.
  localparam logic [KindW-1:0] KindRsvd  = 2'd3;

  localparam logic [AddrW-1:0] RegThreshold = 4'h0;
  localparam logic [AddrW-1:0] RegEnable    = 4'h4;
  localparam logic [AddrW-1:0] RegCooldown  = 4'h8;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic [DataW-1:0]         magnitude;
    logic [DataW-1:0]         noise_floor;
    logic                     last_bin;
    logic signed [AngleW-1:0] x_angle;
    logic signed [AngleW-1:0] y_angle;
    logic [DataW-1:0]         energy;
    logic [DataW-1:0]         tick;
    logic [IdxW-1:0]          read_index;
  } in_item_t;

  typedef struct packed {
    logic                     anomaly;
    logic [DataW-1:0]         frame_deviation;
    logic [BinW-1:0]          frame_peak_bin;
    logic                     read_hit;
    logic [DataW-1:0]         log_tick;
    logic signed [AngleW-1:0] log_x_angle;
    logic signed [AngleW-1:0] log_y_angle;
    logic [DataW-1:0]         log_energy;
    logic [DataW-1:0]         log_deviation;
    logic [BinW-1:0]          log_peak_bin;
    logic [CntW-1:0]          valid_entries;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic div_start; // start the ratio division
    logic div_step;  // one restoring division step
    logic bin_upd;   // fold the ratio into the frame maximum
    logic frame_end; // close the frame, maybe log
    logic read_req;  // issue a log read
    logic read_out;  // form the read result
    logic clear;     // clear the log
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             floor_zero;
    logic             last_bin;
    logic             div_done;
  } sts_t;

endpackage

FILE: rtl/core/sad_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface sad_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/sad_ctrl.sv
// ----------------------------------------------------------------------------
// Anomaly detector controller
// Sequences accept, division, frame close, log read, clear and result hand-off.
// ----------------------------------------------------------------------------
module sad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sad_pkg::sts_t sts_i,
  output sad_pkg::cmd_t cmd_o
);
  import sad_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StUpd   = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StRdOut = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        case (sts_i.kind)
          KindBin: begin
            if (sts_i.floor_zero) begin
              state_d = StUpd;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = StDiv;
            end
          end
          KindRead: begin
            cmd_o.read_req = 1'b1;
            state_d        = StRead;
          end
          KindClear: begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end
          default: state_d = StIdle;
        endcase
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.bin_upd = 1'b1;
        if (sts_i.last_bin) begin
          cmd_o.frame_end = 1'b1;
          state_d         = StOut;
        end else begin
          state_d = StIdle;
        end
      end
      StRead: begin
        cmd_o.read_out = 1'b1;
        state_d        = StRdOut;
      end
      StRdOut: state_d = StOut;
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/sad_datapath.sv
// ----------------------------------------------------------------------------
// Anomaly detector datapath
// Restoring divider, frame maximum, cooldown, log ring and result register.
// ----------------------------------------------------------------------------
module sad_datapath #(
  parameter int unsigned LogDepth = sad_pkg::LogDepthDef,
  parameter int unsigned MaxBins  = sad_pkg::MaxBinsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sad_pkg::in_item_t            item_i,
  input  sad_pkg::cmd_t                cmd_i,
  output sad_pkg::sts_t                sts_o,
  input  logic [sad_pkg::DataW-1:0]    threshold_i,
  input  logic                         detect_enable_i,
  input  logic [sad_pkg::CoolW-1:0]    cooldown_frames_i,
  output sad_pkg::out_item_t           result_o
);
  import sad_pkg::*;

  localparam int unsigned PtrW  = (LogDepth > 1) ? $clog2(LogDepth) : 1;
  localparam int unsigned HeldW = $clog2(LogDepth + 1);
  localparam int unsigned BcW   = $clog2(MaxBins);
  localparam int unsigned QW    = 48;
  localparam int unsigned StepW = $clog2(QW + 1);
  localparam logic [BcW-1:0] BcTop = BcW'(MaxBins - 1);

  in_item_t item_q;

  // Restoring division of magnitude*65536 by floor, one quotient bit a cycle.
  logic [QW-1:0]    quo_q;
  logic [DataW:0]   rem_q;
  logic [StepW-1:0] step_q;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q[DataW-1:0], quo_q[QW-1]};
  assign rem_sub = rem_sh - {1'b0, item_q.noise_floor};
  assign fits    = (rem_sh >= {1'b0, item_q.noise_floor});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.div_start) begin
      quo_q  <= {item_q.magnitude, 16'h0000};
      rem_q  <= '0;
      step_q <= StepW'(QW);
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? rem_sub : rem_sh;
      quo_q  <= {quo_q[QW-2:0], fits};
      step_q <= step_q - StepW'(1);
    end
  end

  assign sts_o.kind       = item_q.kind;
  assign sts_o.floor_zero = (item_q.noise_floor == '0);
  assign sts_o.last_bin   = item_q.last_bin;
  assign sts_o.div_done   = (step_q == StepW'(1));

  logic [DataW-1:0] ratio;
  assign ratio = (quo_q[QW-1:DataW] != '0) ? '1 : quo_q[DataW-1:0];

  logic [DataW-1:0] best_q;
  logic [BinW-1:0]  best_bin_q;
  logic [BcW-1:0]   bin_cnt_q;
  logic [CoolW-1:0] cool_q;
  logic [PtrW-1:0]  wptr_q;
  logic [HeldW-1:0] held_q;

  logic [DataW-1:0] cur_best;
  logic [BinW-1:0]  cur_bin;
  logic             take;
  logic             do_log;

  assign take     = !sts_o.floor_zero && (ratio > best_q);
  assign cur_best = take ? ratio : best_q;
  assign cur_bin  = take ? BinW'(bin_cnt_q) : best_bin_q;
  assign do_log   = cmd_i.frame_end && detect_enable_i && (cool_q == '0)
                    && (cur_best >= threshold_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      best_bin_q <= '0;
      bin_cnt_q  <= '0;
      cool_q     <= '0;
      wptr_q     <= '0;
      held_q     <= '0;
    end else begin
      if (cmd_i.bin_upd) begin
        if (cmd_i.frame_end) begin
          best_q     <= '0;
          best_bin_q <= '0;
          bin_cnt_q  <= '0;
        end else begin
          best_q     <= cur_best;
          best_bin_q <= cur_bin;
          if (bin_cnt_q != BcTop) begin
            bin_cnt_q <= bin_cnt_q + BcW'(1);
          end
        end
      end
      if (cmd_i.frame_end && detect_enable_i && (cool_q != '0)) begin
        cool_q <= cool_q - CoolW'(1);
      end
      if (do_log) begin
        cool_q <= cooldown_frames_i;
        wptr_q <= (wptr_q == PtrW'(LogDepth - 1)) ? '0 : wptr_q + PtrW'(1);
        if (held_q != HeldW'(LogDepth)) begin
          held_q <= held_q + HeldW'(1);
        end
      end
      if (cmd_i.clear) begin
        wptr_q <= '0;
        held_q <= '0;
      end
    end
  end

  // Log ring memory, one wide word per entry.
  localparam int unsigned EntW = 4 * DataW + BinW;
  logic [EntW-1:0] log_mem [LogDepth];
  logic [EntW-1:0] rd_q;
  logic [PtrW-1:0] rd_addr;
  logic [PtrW:0]   rd_sum;
  logic            hit_q;

  assign rd_sum  = {1'b0, wptr_q} + PtrW'(LogDepth - 1)
                   - {1'b0, item_q.read_index[PtrW-1:0]};
  assign rd_addr = (rd_sum >= (PtrW+1)'(LogDepth)) ? PtrW'(rd_sum - (PtrW+1)'(LogDepth))
                                                  : rd_sum[PtrW-1:0];

  always_ff @(posedge clk_i) begin
    if (do_log) begin
      log_mem[wptr_q] <= {item_q.tick, item_q.x_angle, item_q.y_angle,
                          item_q.energy, cur_best, cur_bin};
    end
    if (cmd_i.read_req) begin
      rd_q  <= log_mem[rd_addr];
      hit_q <= ({{(IdxW+1-HeldW){1'b0}}, held_q} > {1'b0, item_q.read_index});
    end
  end

  logic [HeldW-1:0] held_next;
  assign held_next = (do_log && (held_q != HeldW'(LogDepth))) ? held_q + HeldW'(1)
                                                              : held_q;

  out_item_t res_d;

  always_comb begin
    res_d = '0;
    if (cmd_i.frame_end) begin
      res_d.anomaly         = do_log;
      res_d.frame_deviation = cur_best;
      res_d.frame_peak_bin  = cur_bin;
      res_d.valid_entries   = CntW'(held_next);
    end else begin
      res_d.valid_entries = CntW'(held_q);
      if (hit_q) begin
        res_d.read_hit      = 1'b1;
        res_d.log_tick      = rd_q[EntW-1 -: DataW];
        res_d.log_x_angle   = rd_q[EntW-DataW-1 -: AngleW];
        res_d.log_y_angle   = rd_q[EntW-DataW-AngleW-1 -: AngleW];
        res_d.log_energy    = rd_q[2*DataW+BinW-1 -: DataW];
        res_d.log_deviation = rd_q[DataW+BinW-1 -: DataW];
        res_d.log_peak_bin  = rd_q[BinW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_end || cmd_i.read_out) begin
      result_o <= res_d;
    end
  end

endmodule

FILE: rtl/core/sad_regs.sv
// ----------------------------------------------------------------------------
// Anomaly detector register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module sad_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sad_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic [sad_pkg::DataW-1:0]   threshold_o,
  output logic                        detect_enable_o,
  output logic [sad_pkg::CoolW-1:0]   cooldown_frames_o
);
  import sad_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_o       <= ThreshReset;
      detect_enable_o   <= 1'b0;
      cooldown_frames_o <= CooldownReset;
    end else if (wr) begin
      case (paddr)
        RegThreshold: begin
          if (pwdata > ThreshOne) begin
            threshold_o <= pwdata;
          end
        end
        RegEnable:   detect_enable_o   <= pwdata[0];
        RegCooldown: cooldown_frames_o <= pwdata[CoolW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegThreshold: prdata = threshold_o;
      RegEnable:    prdata = {31'd0, detect_enable_o};
      RegCooldown:  prdata = {24'd0, cooldown_frames_o};
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/spectral_anomaly_detector_log_top.sv
// ----------------------------------------------------------------------------
// Spectral anomaly detector top level
// Frame peak-ratio detector with a newest-first anomaly log.
// ----------------------------------------------------------------------------
// Items enter on in_if (valid/ready); results leave on out_if. A bin item
// with a nonzero floor passes accept, decode, 48 divider steps and update;
// one with a zero floor skips the divider. A frame's last bin then holds its
// result in the output register until taken. A log read passes accept,
// decode, log read and result forming before hand-off; a clear gives no
// result. One transaction is in flight at a time, and input ready stays low
// while a result waits, so a stalled receiver simply holds the block. Reset
// clears the frame state, the log count and pointer and the cooldown, and
// loads the register defaults; log contents are not cleared. Configuration
// must be written over the APB port while idle; this is not enforced.
// ----------------------------------------------------------------------------
module spectral_anomaly_detector_log_top #(
  parameter int unsigned LogDepth = sad_pkg::LogDepthDef,
  parameter int unsigned MaxBins  = sad_pkg::MaxBinsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sad_stream_if.sink                in_if,
  sad_stream_if.source              out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sad_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sad_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [DataW-1:0] threshold;
  logic             detect_enable;
  logic [CoolW-1:0] cooldown_frames;

  assign pready = 1'b1;

  sad_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .threshold_o(threshold), .detect_enable_o(detect_enable),
    .cooldown_frames_o(cooldown_frames)
  );

  sad_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  sad_datapath #(.LogDepth(LogDepth), .MaxBins(MaxBins)) u_dp (
    .clk_i, .rst_ni, .item_i(in_if.payload), .cmd_i(cmd), .sts_o(sts),
    .threshold_i(threshold), .detect_enable_i(detect_enable),
    .cooldown_frames_i(cooldown_frames), .result_o(out_if.payload)
  );

endmodule

FILE: tb/tb_sad_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral anomaly detector scoreboard
// Tracks detector state for each accepted transaction and checks results in
// order against the expected values it produces.
// ----------------------------------------------------------------------------
class sad_scoreboard;
  localparam int unsigned Depth = 16;
  localparam int unsigned BinTop = 1023;

  logic [31:0] thresh;
  logic        enable;
  logic [7:0]  cool_frames;

  logic [31:0] ev_tick   [Depth];
  logic [15:0] ev_x      [Depth];
  logic [15:0] ev_y      [Depth];
  logic [31:0] ev_energy [Depth];
  logic [31:0] ev_ratio  [Depth];
  logic [9:0]  ev_bin    [Depth];
  int unsigned wr_ptr;
  int unsigned held;
  int unsigned cool_left;
  logic [31:0] peak_ratio;
  logic [9:0]  best_idx;
  int unsigned bin_idx;

  sad_pkg::out_item_t pending_q[$];
  int unsigned errors;

  function new();
    thresh = sad_pkg::ThreshReset;
    enable = 1'b0;
    cool_frames = sad_pkg::CooldownReset;
    wr_ptr = 0; held = 0; cool_left = 0;
    peak_ratio = '0; best_idx = '0; bin_idx = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [3:0] addr, logic [31:0] data);
    if (addr == sad_pkg::RegThreshold) begin
      if (data > sad_pkg::ThreshOne) thresh = data;
    end else if (addr == sad_pkg::RegEnable) begin
      enable = data[0];
    end else if (addr == sad_pkg::RegCooldown) begin
      cool_frames = data[7:0];
    end
  endfunction

  function void note_input(sad_pkg::in_item_t it);
    sad_pkg::out_item_t res;
    logic [63:0] quo;
    logic [31:0] ratio;
    int unsigned slot;
    res = '0;
    if (it.kind == sad_pkg::KindBin) begin
      if (it.noise_floor != 0) begin
        quo = {it.magnitude, 16'h0} / {32'h0, it.noise_floor};
        ratio = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        if (ratio > peak_ratio) begin
          peak_ratio = ratio;
          best_idx = bin_idx[9:0];
        end
      end
      if (bin_idx < BinTop) bin_idx++;
      if (!it.last_bin) return;
      res.frame_deviation = peak_ratio;
      res.frame_peak_bin = best_idx;
      if (enable) begin
        if (cool_left > 0) begin
          cool_left--;
        end else if (peak_ratio >= thresh) begin
          ev_tick[wr_ptr] = it.tick;
          ev_x[wr_ptr] = it.x_angle;
          ev_y[wr_ptr] = it.y_angle;
          ev_energy[wr_ptr] = it.energy;
          ev_ratio[wr_ptr] = peak_ratio;
          ev_bin[wr_ptr] = best_idx;
          wr_ptr = (wr_ptr + 1) % Depth;
          if (held < Depth) held++;
          cool_left = cool_frames;
          res.anomaly = 1'b1;
        end
      end
      peak_ratio = '0; best_idx = '0; bin_idx = 0;
      res.valid_entries = held[4:0];
      pending_q.push_back(res);
    end else if (it.kind == sad_pkg::KindRead) begin
      if (it.read_index < held) begin
        slot = (wr_ptr + Depth - 1 - it.read_index) % Depth;
        res.read_hit = 1'b1;
        res.log_tick = ev_tick[slot];
        res.log_x_angle = ev_x[slot];
        res.log_y_angle = ev_y[slot];
        res.log_energy = ev_energy[slot];
        res.log_deviation = ev_ratio[slot];
        res.log_peak_bin = ev_bin[slot];
      end
      res.valid_entries = held[4:0];
      pending_q.push_back(res);
    end else if (it.kind == sad_pkg::KindClear) begin
      wr_ptr = 0; held = 0;
    end
  endfunction

  function void check_result(sad_pkg::out_item_t got);
    sad_pkg::out_item_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected result transaction %h", got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.anomaly !== exp_r.anomaly) begin
      $error("anomaly exp %0d got %0d", exp_r.anomaly, got.anomaly); errors++;
    end
    if (got.frame_deviation !== exp_r.frame_deviation) begin
      $error("frame_deviation exp %h got %h", exp_r.frame_deviation, got.frame_deviation);
      errors++;
    end
    if (got.frame_peak_bin !== exp_r.frame_peak_bin) begin
      $error("frame_peak_bin exp %0d got %0d", exp_r.frame_peak_bin, got.frame_peak_bin);
      errors++;
    end
    if (got.read_hit !== exp_r.read_hit) begin
      $error("read_hit exp %0d got %0d", exp_r.read_hit, got.read_hit); errors++;
    end
    if (got.log_tick !== exp_r.log_tick) begin
      $error("log_tick exp %h got %h", exp_r.log_tick, got.log_tick); errors++;
    end
    if (got.log_x_angle !== exp_r.log_x_angle) begin
      $error("log_x_angle exp %h got %h", exp_r.log_x_angle, got.log_x_angle); errors++;
    end
    if (got.log_y_angle !== exp_r.log_y_angle) begin
      $error("log_y_angle exp %h got %h", exp_r.log_y_angle, got.log_y_angle); errors++;
    end
    if (got.log_energy !== exp_r.log_energy) begin
      $error("log_energy exp %h got %h", exp_r.log_energy, got.log_energy); errors++;
    end
    if (got.log_deviation !== exp_r.log_deviation) begin
      $error("log_deviation exp %h got %h", exp_r.log_deviation, got.log_deviation);
      errors++;
    end
    if (got.log_peak_bin !== exp_r.log_peak_bin) begin
      $error("log_peak_bin exp %0d got %0d", exp_r.log_peak_bin, got.log_peak_bin);
      errors++;
    end
    if (got.valid_entries !== exp_r.valid_entries) begin
      $error("valid_entries exp %0d got %0d", exp_r.valid_entries, got.valid_entries);
      errors++;
    end
  endfunction
endclass

FILE: tb/tb_spectral_anomaly_detector_log_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral anomaly detector testbench
// Directed and random bins, log reads, clears and reserved items under several
// idle and stall mixes, with register changes between phases, checked in order.
// ----------------------------------------------------------------------------
module tb_spectral_anomaly_detector_log_top;
  import sad_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sad_stream_if #(.payload_t(in_item_t))  in_if ();
  sad_stream_if #(.payload_t(out_item_t)) out_if ();

  spectral_anomaly_detector_log_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sad_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned frame_bins = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: ready is set at the falling edge, results taken at the rising edge.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  // Valid stays high after an accepted transaction so that the next one can
  // follow back to back; it drops only while the sender idles.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.payload <= it;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    // A bin without a result may still be inside the divider.
    repeat (60) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [AddrW-1:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr, data);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic in_item_t rand_bin(bit last);
    in_item_t it;
    it = '0;
    it.kind = KindBin;
    it.last_bin = last;
    case ($urandom_range(5))
      0: begin it.magnitude = $urandom; it.noise_floor = $urandom; end
      1: begin it.magnitude = $urandom; it.noise_floor = $urandom_range(255); end
      2: begin it.magnitude = $urandom; it.noise_floor = 0; end
      default: begin
        it.noise_floor = $urandom_range(32'h0002_0000, 32'h0000_4000);
        it.magnitude = $urandom_range(32'h0010_0000);
      end
    endcase
    it.x_angle = 16'($urandom); it.y_angle = 16'($urandom);
    it.energy = $urandom; it.tick = $urandom;
    return it;
  endfunction

  task automatic send_read(int unsigned idx);
    in_item_t it;
    it = '0;
    it.kind = KindRead;
    it.read_index = idx[7:0];
    send_item(it);
  endtask

  task automatic send_clear();
    in_item_t it;
    it = '0;
    it.kind = KindClear;
    send_item(it);
  endtask

  task automatic random_run(int unsigned n);
    in_item_t it;
    int unsigned sel;
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        frame_bins++;
        send_item(rand_bin(frame_bins >= $urandom_range(6, 1)));
        if (in_if.payload.last_bin) frame_bins = 0;
      end else if (sel < 93) begin
        // Hits read entries already written; misses go beyond the count.
        if (sb.held > 0 && $urandom_range(3) != 0) send_read($urandom_range(sb.held - 1));
        else send_read($urandom_range(255, sb.held));
      end else if (sel < 97) begin
        send_clear();
      end else begin
        it = '0;
        it.kind = KindRsvd;
        it.magnitude = $urandom;
        it.noise_floor = $urandom;
        it.last_bin = 1'b1;
        send_item(it);
      end
    end
  endtask

  initial begin
    in_item_t it;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, skipped bins, saturation, detection off and on.
    send_read(0);
    it = '0; it.magnitude = 32'hFFFF_FFFF; it.noise_floor = 32'h1; it.last_bin = 1'b1;
    send_item(it);
    apb_write(RegEnable, 32'h1);
    apb_write(RegCooldown, 32'h0);
    apb_write(RegThreshold, 32'h0001_0000);
    apb_write(RegThreshold, 32'h0001_0001);
    it = '0; it.magnitude = 32'h0001_0000; it.noise_floor = 32'h0; send_item(it);
    it.magnitude = 32'h0003_0000; it.noise_floor = 32'h0001_0000; send_item(it);
    it.magnitude = 32'h0003_0000; send_item(it);
    it.magnitude = 0; it.noise_floor = 32'hFFFF_FFFF; it.last_bin = 1'b1;
    it.x_angle = 16'sh8000; it.y_angle = 16'sh7FFF; it.energy = 32'hFFFF_FFFF;
    it.tick = 32'hFFFF_FFFF; send_item(it);
    it = '0; it.last_bin = 1'b1; it.noise_floor = 32'h0; it.x_angle = 16'sh7FFF;
    it.y_angle = 16'sh8000; send_item(it);
    it = '0; it.magnitude = 32'hFFFF_FFFF; it.noise_floor = 32'hFFFF_FFFF;
    it.last_bin = 1'b1; it.tick = 32'h1234_5678; send_item(it);
    send_read(0); send_read(1); send_read(2); send_read(255);
    send_clear(); send_read(0);
    it = '0; it.kind = KindRsvd; send_item(it);
    it = '0; it.magnitude = 32'hFFFF_FFFF; it.noise_floor = 32'h1; it.last_bin = 1'b1;
    send_item(it); send_read(0);
    // Fill the bin counter past its top so the peak sits at the saturated index.
    for (int i = 0; i < 1030; i++) begin
      it = '0; it.kind = KindBin; it.noise_floor = 0; send_item(it);
    end
    it.magnitude = 32'h0005_0000; it.noise_floor = 32'h0001_0000; it.last_bin = 1'b1;
    send_item(it);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 76; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 76; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      apb_write(RegThreshold, (ph == 0) ? 32'hFFFF_FFFF : $urandom_range(32'h0008_0000,
                32'h0001_8000));
      apb_write(RegEnable, (ph != 1) ? 32'h1 : 32'h0);
      apb_write(RegCooldown, (ph == 2) ? 32'hFF : $urandom_range(3));
      if (ph == 2) hold_cycles = 600;
      random_run(200);
      drain();
    end
    apb_write(RegCooldown, 32'h0);
    apb_write(RegEnable, 32'h1);
    random_run(60);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_spectral_anomaly_detector_log_top: done, clean");
    end else begin
      $display("tb_spectral_anomaly_detector_log_top: done, errors");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("tb_spectral_anomaly_detector_log_top: done, errors");
    $finish;
  end
endmodule
